// ----- sv/xlc_pkg.sv -----
// ----------------------------------------------------------------------------
// xlc_pkg
// shared types and constants of the xoodoo linear and chi layer core
// ----------------------------------------------------------------------------
package xlc_pkg;

  // geometry of the state
  localparam int unsigned NumCols   = 4;
  localparam int unsigned NumPlanes = 3;
  localparam int unsigned NumLanes  = NumCols * NumPlanes;

  // width of a lane field on the ports
  localparam int unsigned FieldBits = 32;

  // default lane width inside the datapath
  localparam int unsigned DefaultLaneBits = 32;

  // rotation amounts
  localparam int unsigned RhoeRotP1  = 1;
  localparam int unsigned RhoeRotP2  = 8;
  localparam int unsigned RhoeShiftP2 = 2;
  localparam int unsigned ThetaRotA  = 5;
  localparam int unsigned ThetaRotB  = 14;
  localparam int unsigned RhowRotP2  = 11;
  localparam int unsigned RhowShiftP1 = 1;

  // configuration port
  localparam int unsigned DataBits = 32;
  localparam int unsigned AddrBits = 3;

  // register indexes
  localparam logic [AddrBits-3:0] RegOperation = '0;

  // operation codes; the unused code behaves as linear then chi
  typedef enum logic [1:0] {
    OP_LINEAR = 2'd0,
    OP_CHI    = 2'd1,
    OP_BOTH   = 2'd2
  } op_e;

  // per word control that travels down the pipeline
  typedef struct packed {
    logic lambda_en;
    logic chi_en;
  } ctrl_t;

  typedef struct packed {
    logic [FieldBits-1:0] in_p0_x0;
    logic [FieldBits-1:0] in_p0_x1;
    logic [FieldBits-1:0] in_p0_x2;
    logic [FieldBits-1:0] in_p0_x3;
    logic [FieldBits-1:0] in_p1_x0;
    logic [FieldBits-1:0] in_p1_x1;
    logic [FieldBits-1:0] in_p1_x2;
    logic [FieldBits-1:0] in_p1_x3;
    logic [FieldBits-1:0] in_p2_x0;
    logic [FieldBits-1:0] in_p2_x1;
    logic [FieldBits-1:0] in_p2_x2;
    logic [FieldBits-1:0] in_p2_x3;
  } in_word_t;

  typedef struct packed {
    logic [FieldBits-1:0] out_p0_x0;
    logic [FieldBits-1:0] out_p0_x1;
    logic [FieldBits-1:0] out_p0_x2;
    logic [FieldBits-1:0] out_p0_x3;
    logic [FieldBits-1:0] out_p1_x0;
    logic [FieldBits-1:0] out_p1_x1;
    logic [FieldBits-1:0] out_p1_x2;
    logic [FieldBits-1:0] out_p1_x3;
    logic [FieldBits-1:0] out_p2_x0;
    logic [FieldBits-1:0] out_p2_x1;
    logic [FieldBits-1:0] out_p2_x2;
    logic [FieldBits-1:0] out_p2_x3;
  } out_word_t;

endpackage

// ----- sv/xlc_rhoe_stage.sv -----
// ----------------------------------------------------------------------------
// xlc_rhoe_stage
// first pipeline stage: rhoE shifts and column parity
// ----------------------------------------------------------------------------
module xlc_rhoe_stage #(
  parameter int unsigned LaneBits = xlc_pkg::DefaultLaneBits
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  xlc_pkg::ctrl_t                                 ctrl_i,
  input  logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output xlc_pkg::ctrl_t                                 ctrl_o,
  output logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_o,
  output logic [xlc_pkg::NumCols-1:0][LaneBits-1:0]      parity_o
);
  import xlc_pkg::*;

  localparam int unsigned RotP1 = RhoeRotP1 % LaneBits;
  localparam int unsigned RotP2 = RhoeRotP2 % LaneBits;

  function automatic logic [LaneBits-1:0] rotl(input logic [LaneBits-1:0] v,
                                               input int unsigned r);
    logic [2*LaneBits-1:0] w;
    w = {v, v} << r;
    return w[2*LaneBits-1 -: LaneBits];
  endfunction

  logic [NumLanes-1:0][LaneBits-1:0] lanes_d, lanes_q;
  logic [NumCols-1:0][LaneBits-1:0]  parity_d, parity_q;
  ctrl_t                             ctrl_q;
  logic                              valid_q;

  for (genvar x = 0; x < NumCols; x++) begin : g_col
    localparam int unsigned SrcX = (x + NumCols - RhoeShiftP2) % NumCols;
    always_comb begin
      lanes_d[x] = lanes_i[x];
      if (ctrl_i.lambda_en) begin
        lanes_d[NumCols + x]   = rotl(lanes_i[NumCols + x], RotP1);
        lanes_d[2*NumCols + x] = rotl(lanes_i[2*NumCols + SrcX], RotP2);
      end else begin
        lanes_d[NumCols + x]   = lanes_i[NumCols + x];
        lanes_d[2*NumCols + x] = lanes_i[2*NumCols + x];
      end
      parity_d[x] = lanes_d[x] ^ lanes_d[NumCols + x] ^ lanes_d[2*NumCols + x];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lanes_q  <= lanes_d;
      parity_q <= parity_d;
      ctrl_q   <= ctrl_i;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign lanes_o  = lanes_q;
  assign parity_o = parity_q;

endmodule

// ----- sv/xlc_theta_stage.sv -----
// ----------------------------------------------------------------------------
// xlc_theta_stage
// second pipeline stage: theta column mixing and rhoW shifts
// ----------------------------------------------------------------------------
module xlc_theta_stage #(
  parameter int unsigned LaneBits = xlc_pkg::DefaultLaneBits
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  xlc_pkg::ctrl_t                                 ctrl_i,
  input  logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_i,
  input  logic [xlc_pkg::NumCols-1:0][LaneBits-1:0]      parity_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output xlc_pkg::ctrl_t                                 ctrl_o,
  output logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_o
);
  import xlc_pkg::*;

  localparam int unsigned RotA  = ThetaRotA % LaneBits;
  localparam int unsigned RotB  = ThetaRotB % LaneBits;
  localparam int unsigned RotW2 = RhowRotP2 % LaneBits;

  function automatic logic [LaneBits-1:0] rotl(input logic [LaneBits-1:0] v,
                                               input int unsigned r);
    logic [2*LaneBits-1:0] w;
    w = {v, v} << r;
    return w[2*LaneBits-1 -: LaneBits];
  endfunction

  logic [NumCols-1:0][LaneBits-1:0]  effect;
  logic [NumLanes-1:0][LaneBits-1:0] mixed;
  logic [NumLanes-1:0][LaneBits-1:0] lanes_d, lanes_q;
  ctrl_t                             ctrl_q;
  logic                              valid_q;

  // theta: each column takes the folded parity of its left neighbor
  for (genvar x = 0; x < NumCols; x++) begin : g_theta
    localparam int unsigned PrevX = (x + NumCols - 1) % NumCols;
    assign effect[x] = rotl(parity_i[PrevX], RotA) ^ rotl(parity_i[PrevX], RotB);
    for (genvar y = 0; y < NumPlanes; y++) begin : g_plane
      assign mixed[y*NumCols + x] = lanes_i[y*NumCols + x] ^ effect[x];
    end
  end

  // rhoW
  for (genvar x = 0; x < NumCols; x++) begin : g_rhow
    localparam int unsigned SrcX = (x + NumCols - RhowShiftP1) % NumCols;
    always_comb begin
      if (ctrl_i.lambda_en) begin
        lanes_d[x]             = mixed[x];
        lanes_d[NumCols + x]   = mixed[NumCols + SrcX];
        lanes_d[2*NumCols + x] = rotl(mixed[2*NumCols + x], RotW2);
      end else begin
        lanes_d[x]             = lanes_i[x];
        lanes_d[NumCols + x]   = lanes_i[NumCols + x];
        lanes_d[2*NumCols + x] = lanes_i[2*NumCols + x];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lanes_q <= lanes_d;
      ctrl_q  <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign lanes_o = lanes_q;

endmodule

// ----- sv/xlc_chi_stage.sv -----
// ----------------------------------------------------------------------------
// xlc_chi_stage
// last pipeline stage: chi per column, output register
// ----------------------------------------------------------------------------
module xlc_chi_stage #(
  parameter int unsigned LaneBits = xlc_pkg::DefaultLaneBits
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  xlc_pkg::ctrl_t                                 ctrl_i,
  input  logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output logic [xlc_pkg::NumLanes-1:0][LaneBits-1:0]     lanes_o
);
  import xlc_pkg::*;

  logic [NumLanes-1:0][LaneBits-1:0] lanes_d, lanes_q;
  logic                              valid_q;

  for (genvar x = 0; x < NumCols; x++) begin : g_col
    for (genvar y = 0; y < NumPlanes; y++) begin : g_plane
      localparam int unsigned Y1 = (y + 1) % NumPlanes;
      localparam int unsigned Y2 = (y + 2) % NumPlanes;
      always_comb begin
        if (ctrl_i.chi_en) begin
          lanes_d[y*NumCols + x] = lanes_i[y*NumCols + x]
                                 ^ (~lanes_i[Y1*NumCols + x] & lanes_i[Y2*NumCols + x]);
        end else begin
          lanes_d[y*NumCols + x] = lanes_i[y*NumCols + x];
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// ----- sv/xoodoo_linear_and_chi_layer_core.sv -----
// ----------------------------------------------------------------------------
// xoodoo_linear_and_chi_layer_core
// xoodoo round layers (lambda, chi, or both) on a 384-bit state, pipelined
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 word
//   --------  ---------  ------------------------  ----------------------------
//   input     in         in_valid_i / in_ready_o   in_word_i, twelve lanes
//   output    out        out_valid_o / out_ready_i out_word_o, twelve lanes
//   config    in         apb psel/penable/pready   operation register
//
// three register stages (rhoE + parity, theta + rhoW, chi); one word enters
// every cycle unless the pipe is stalled; an accepted word passes the rhoE,
// theta and chi registers in order, is then on the output and leaves with out_ready_i
// each stage holds its word while the next one is stalled, so a full pipe
// keeps three words and nothing is dropped or repeated
// reset clears only the valid bits and the operation register (to linear)
// the operation is sampled with each word and travels with it
//
module xoodoo_linear_and_chi_layer_core #(
  parameter int unsigned LaneBits = xlc_pkg::DefaultLaneBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  xlc_pkg::in_word_t                in_word_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output xlc_pkg::out_word_t               out_word_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [xlc_pkg::AddrBits-1:0]     paddr,
  input  logic [xlc_pkg::DataBits-1:0]     pwdata,
  output logic [xlc_pkg::DataBits-1:0]     prdata,
  output logic                             pready
);
  import xlc_pkg::*;

  // operation register
  logic [1:0] op_d, op_q;
  logic       reg_hit;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[AddrBits-1:2] == RegOperation);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    op_d = op_q;
    if (cfg_write && reg_hit) begin
      op_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_LINEAR;
    end else begin
      op_q <= op_d;
    end
  end

  // reads return the register, anything else reads as zero
  assign prdata = reg_hit ? {{(DataBits-2){1'b0}}, op_q} : '0;

  // decode: lambda unless chi only, chi unless linear only
  ctrl_t in_ctrl;
  assign in_ctrl.lambda_en = (op_q != OP_CHI);
  assign in_ctrl.chi_en    = (op_q != OP_LINEAR);

  // unpack the input word into lanes indexed plane * 4 + column
  logic [NumLanes-1:0][FieldBits-1:0] in_fields;
  logic [NumLanes-1:0][LaneBits-1:0]  in_lanes;
  logic [NumLanes-1:0][FieldBits-1:0] out_fields;
  logic [NumLanes-1:0][LaneBits-1:0]  out_lanes;

  assign in_fields[0]  = in_word_i.in_p0_x0;
  assign in_fields[1]  = in_word_i.in_p0_x1;
  assign in_fields[2]  = in_word_i.in_p0_x2;
  assign in_fields[3]  = in_word_i.in_p0_x3;
  assign in_fields[4]  = in_word_i.in_p1_x0;
  assign in_fields[5]  = in_word_i.in_p1_x1;
  assign in_fields[6]  = in_word_i.in_p1_x2;
  assign in_fields[7]  = in_word_i.in_p1_x3;
  assign in_fields[8]  = in_word_i.in_p2_x0;
  assign in_fields[9]  = in_word_i.in_p2_x1;
  assign in_fields[10] = in_word_i.in_p2_x2;
  assign in_fields[11] = in_word_i.in_p2_x3;

  // narrow lanes drop the upper field bits, wide lanes zero-extend;
  // on the way out the reverse
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane_io
    if (LaneBits < FieldBits) begin : g_narrow
      assign in_lanes[i]   = in_fields[i][LaneBits-1:0];
      assign out_fields[i] = {{(FieldBits-LaneBits){1'b0}}, out_lanes[i]};
    end else if (LaneBits == FieldBits) begin : g_equal
      assign in_lanes[i]   = in_fields[i];
      assign out_fields[i] = out_lanes[i];
    end else begin : g_wide
      assign in_lanes[i]   = {{(LaneBits-FieldBits){1'b0}}, in_fields[i]};
      assign out_fields[i] = out_lanes[i][FieldBits-1:0];
    end
  end

  assign out_word_o.out_p0_x0 = out_fields[0];
  assign out_word_o.out_p0_x1 = out_fields[1];
  assign out_word_o.out_p0_x2 = out_fields[2];
  assign out_word_o.out_p0_x3 = out_fields[3];
  assign out_word_o.out_p1_x0 = out_fields[4];
  assign out_word_o.out_p1_x1 = out_fields[5];
  assign out_word_o.out_p1_x2 = out_fields[6];
  assign out_word_o.out_p1_x3 = out_fields[7];
  assign out_word_o.out_p2_x0 = out_fields[8];
  assign out_word_o.out_p2_x1 = out_fields[9];
  assign out_word_o.out_p2_x2 = out_fields[10];
  assign out_word_o.out_p2_x3 = out_fields[11];

  // stage 1 -> stage 2
  logic                              s1_valid, s1_ready;
  ctrl_t                             s1_ctrl;
  logic [NumLanes-1:0][LaneBits-1:0] s1_lanes;
  logic [NumCols-1:0][LaneBits-1:0]  s1_parity;

  // stage 2 -> stage 3
  logic                              s2_valid, s2_ready;
  ctrl_t                             s2_ctrl;
  logic [NumLanes-1:0][LaneBits-1:0] s2_lanes;

  xlc_rhoe_stage #(
    .LaneBits (LaneBits)
  ) u_rhoe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .ctrl_i   (in_ctrl),
    .lanes_i  (in_lanes),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .ctrl_o   (s1_ctrl),
    .lanes_o  (s1_lanes),
    .parity_o (s1_parity)
  );

  xlc_theta_stage #(
    .LaneBits (LaneBits)
  ) u_theta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .ctrl_i   (s1_ctrl),
    .lanes_i  (s1_lanes),
    .parity_i (s1_parity),
    .valid_o  (s2_valid),
    .ready_i  (s2_ready),
    .ctrl_o   (s2_ctrl),
    .lanes_o  (s2_lanes)
  );

  xlc_chi_stage #(
    .LaneBits (LaneBits)
  ) u_chi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .ctrl_i  (s2_ctrl),
    .lanes_i (s2_lanes),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .lanes_o (out_lanes)
  );

endmodule
